/* hdl/ptq_pkg.sv */
// shared types and constants of the preemptive task queue
package ptq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_WIDTH_DEF    = 32;
  localparam int unsigned TYPE_COUNT_DEF  = 16;

  localparam int unsigned TYPE_W    = 4;
  localparam int unsigned TGT_W     = 32;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned WAIT_W    = 5;
  localparam logic [MASK_W-1:0] MASK_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_FINISH = 2'd2
  } ptq_kind_e;

  typedef enum logic [1:0] {
    MODE_TAIL    = 2'd0,
    MODE_PREEMPT = 2'd1,
    MODE_CLEAR   = 2'd2
  } ptq_mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } ptq_status_e;

  typedef enum logic [1:0] {
    OP_HOLD    = 2'd0,
    OP_PREPEND = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_APPEND  = 2'd3
  } ptq_op_e;

  typedef struct packed {
    ptq_op_e op;
    logic    tgt_ok;
  } ptq_cell_ctrl_t;

endpackage

/* hdl/ptq_cell.sv */
// one queue cell: holds a waiting task, matches ids and shifts with its neighbors
module ptq_cell import ptq_pkg::*; #(
  parameter int unsigned IdW = ID_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  ptq_cell_ctrl_t              ctrl_i,
  input  logic [IdW-1:0]              tgt_id_i,
  input  logic [IdW+TYPE_W:0]         ins_i,
  input  logic [IdW+TYPE_W:0]         left_i,
  input  logic [IdW+TYPE_W:0]         right_i,
  input  logic                        occ_i,
  input  logic                        occ_prev_i,
  input  logic                        hit_i,
  output logic                        hit_o,
  output logic [IdW+TYPE_W:0]         entry_o
);

  localparam int unsigned EntryW = IdW + TYPE_W + 1;

  logic [EntryW-1:0] entry_q, entry_d;
  logic              match;

  assign match   = occ_i && ctrl_i.tgt_ok && (entry_q[EntryW-1 -: IdW] == tgt_id_i);
  assign hit_o   = hit_i | match;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      OP_PREPEND: entry_d = left_i;
      OP_REMOVE: begin
        if (hit_o) entry_d = right_i;
      end
      OP_APPEND: begin
        if (occ_prev_i && !occ_i) entry_d = ins_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* hdl/preemptive_task_queue_core.sv */
// top level of the preemptive task queue: current slot, id counter and chain of queue cells
//
//  channel  direction  handshake                payload
//  in       in         in_valid_i / in_stall_o  kind, preempt_mode, can_be_preempted,
//                                               task_type, target_id
//  out      out        out_valid_o / out_stall_i assigned_id, status, stop_*, start_*,
//                                               dispatch_ok, running, waiting_count
//  cfg      in         cfg_valid_i / cfg_ready_o registered_type_mask (cfg_data_i)
//
//  a taken item's result beat is in the output register on the next cycle
//  a new item is taken each cycle while the output register is empty or being drained
//  the cell chain matches ids and finds the first hit combinationally and registers shifts
//  reset clears the current slot, the id counter, the queue count and the output valid
//  in_stall_o is high only while a result beat waits and out_stall_i is high
module preemptive_task_queue_core import ptq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned ID_WIDTH    = ID_WIDTH_DEF,
  parameter int unsigned TYPE_COUNT  = TYPE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        kind_i,
  input  logic [1:0]        preempt_mode_i,
  input  logic              can_be_preempted_i,
  input  logic [TYPE_W-1:0] task_type_i,
  input  logic [TGT_W-1:0]  target_id_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [TGT_W-1:0]  assigned_id_o,
  output logic [1:0]        status_o,
  output logic              stop_valid_o,
  output logic [TGT_W-1:0]  stop_id_o,
  output logic [TYPE_W-1:0] stop_type_o,
  output logic              start_valid_o,
  output logic [TGT_W-1:0]  start_id_o,
  output logic [TYPE_W-1:0] start_type_o,
  output logic              dispatch_ok_o,
  output logic              running_o,
  output logic [WAIT_W-1:0] waiting_count_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [MASK_W-1:0] cfg_data_i
);

  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EntryW = ID_WIDTH + TYPE_W + 1;

  logic                  accept;
  logic [MASK_W-1:0]     mask_q;
  logic [ID_WIDTH-1:0]   ctr_q, ctr_d, new_id;
  logic                  cur_valid_q, cur_valid_d;
  logic [ID_WIDTH-1:0]   cur_id_q, cur_id_d;
  logic [TYPE_W-1:0]     cur_type_q, cur_type_d;
  logic                  cur_pre_q, cur_pre_d;
  logic [CntW-1:0]       count_q, count_d;

  logic [ID_WIDTH-1:0]   tgt_cmp;
  logic                  tgt_ok, cur_hit, seed, q_hit, full, need_slot;
  logic [EntryW-1:0]     new_ent, cur_ent, ins_ent, start_ent;
  logic [EntryW-1:0]     ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ;
  logic [QUEUE_DEPTH:0]  hit;
  ptq_op_e               op;
  ptq_cell_ctrl_t        ctrl;

  ptq_status_e           status;
  logic [ID_WIDTH-1:0]   assigned;
  logic                  stop_v, start_v, disp_ok;

  logic                  out_valid_q;
  logic [TGT_W-1:0]      out_assigned_q, out_stop_id_q, out_start_id_q;
  ptq_status_e           out_status_q;
  logic                  out_stop_v_q, out_start_v_q, out_disp_ok_q, out_running_q;
  logic [TYPE_W-1:0]     out_stop_type_q, out_start_type_q;
  logic [WAIT_W-1:0]     out_wait_q;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  // target compare: bits above the id width must be zero
  assign tgt_cmp   = ID_WIDTH'(target_id_i);
  assign tgt_ok    = ((target_id_i >> ID_WIDTH) == '0);
  assign cur_hit   = cur_valid_q && tgt_ok && (cur_id_q == tgt_cmp);
  assign seed      = ((kind_i == KIND_DELETE) || (kind_i == KIND_FINISH)) && cur_hit;
  assign q_hit     = hit[QUEUE_DEPTH];
  assign full      = (count_q == CntW'(QUEUE_DEPTH));
  assign need_slot = cur_valid_q && (preempt_mode_i != MODE_CLEAR);
  assign new_id    = ctr_q + ID_WIDTH'(1);
  assign new_ent   = {new_id, task_type_i, can_be_preempted_i};
  assign cur_ent   = {cur_id_q, cur_type_q, cur_pre_q};

  assign hit[0]    = seed;
  assign ctrl.op     = accept ? op : OP_HOLD;
  assign ctrl.tgt_ok = tgt_ok;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [EntryW-1:0] left, right;
    logic              occ_prev;

    assign occ[i] = (CntW'(i) < count_q);
    if (i == 0) begin : g_first
      assign left     = ins_ent;
      assign occ_prev = 1'b1;
    end else begin : g_mid
      assign left     = ent[i-1];
      assign occ_prev = occ[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = ent[i];
    end else begin : g_inner
      assign right = ent[i+1];
    end

    ptq_cell #(.IdW(ID_WIDTH)) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .tgt_id_i   (tgt_cmp),
      .ins_i      (ins_ent),
      .left_i     (left),
      .right_i    (right),
      .occ_i      (occ[i]),
      .occ_prev_i (occ_prev),
      .hit_i      (hit[i]),
      .hit_o      (hit[i+1]),
      .entry_o    (ent[i])
    );
  end

  always_comb begin
    op          = OP_HOLD;
    ins_ent     = new_ent;
    start_ent   = new_ent;
    status      = ST_OK;
    assigned    = '0;
    stop_v      = 1'b0;
    start_v     = 1'b0;
    ctr_d       = ctr_q;
    cur_valid_d = cur_valid_q;
    count_d     = count_q;
    case (kind_i)
      KIND_ADD: begin
        if (need_slot && full) begin
          status = ST_FULL;
        end else begin
          ctr_d    = new_id;
          assigned = new_id;
          if (!cur_valid_q) begin
            start_v = 1'b1;
          end else begin
            case (preempt_mode_i)
              MODE_PREEMPT: begin
                op      = OP_PREPEND;
                count_d = count_q + CntW'(1);
                if (cur_pre_q) begin
                  stop_v  = 1'b1;
                  start_v = 1'b1;
                  ins_ent = cur_ent;
                end
              end
              MODE_CLEAR: begin
                if (cur_pre_q) begin
                  stop_v  = 1'b1;
                  start_v = 1'b1;
                  count_d = '0;
                end else begin
                  op      = OP_PREPEND;
                  count_d = CntW'(1);
                end
              end
              default: begin
                op      = OP_APPEND;
                count_d = count_q + CntW'(1);
              end
            endcase
          end
        end
      end
      KIND_DELETE, KIND_FINISH: begin
        if (cur_hit) begin
          stop_v = (kind_i == KIND_DELETE);
          if (count_q != '0) begin
            start_v   = 1'b1;
            start_ent = ent[0];
            op        = OP_REMOVE;
            count_d   = count_q - CntW'(1);
          end else begin
            cur_valid_d = 1'b0;
          end
        end else if (q_hit) begin
          op      = OP_REMOVE;
          count_d = count_q - CntW'(1);
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    if (start_v) cur_valid_d = 1'b1;
    cur_id_d   = start_v ? start_ent[EntryW-1 -: ID_WIDTH] : cur_id_q;
    cur_type_d = start_v ? start_ent[TYPE_W:1] : cur_type_q;
    cur_pre_d  = start_v ? start_ent[0] : cur_pre_q;
    disp_ok    = start_v && (int'(start_ent[TYPE_W:1]) < TYPE_COUNT)
                 && mask_q[start_ent[TYPE_W:1]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= MASK_RESET;
      ctr_q       <= '0;
      cur_valid_q <= 1'b0;
      cur_id_q    <= '0;
      cur_type_q  <= '0;
      cur_pre_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) mask_q <= cfg_data_i;
      if (accept) begin
        ctr_q       <= ctr_d;
        cur_valid_q <= cur_valid_d;
        cur_id_q    <= cur_id_d;
        cur_type_q  <= cur_type_d;
        cur_pre_q   <= cur_pre_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_assigned_q   <= TGT_W'(assigned);
      out_status_q     <= status;
      out_stop_v_q     <= stop_v;
      out_stop_id_q    <= stop_v ? TGT_W'(cur_id_q) : '0;
      out_stop_type_q  <= stop_v ? cur_type_q : '0;
      out_start_v_q    <= start_v;
      out_start_id_q   <= start_v ? TGT_W'(start_ent[EntryW-1 -: ID_WIDTH]) : '0;
      out_start_type_q <= start_v ? start_ent[TYPE_W:1] : '0;
      out_disp_ok_q    <= disp_ok;
      out_running_q    <= cur_valid_d;
      out_wait_q       <= WAIT_W'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign assigned_id_o   = out_assigned_q;
  assign status_o        = out_status_q;
  assign stop_valid_o    = out_stop_v_q;
  assign stop_id_o       = out_stop_id_q;
  assign stop_type_o     = out_stop_type_q;
  assign start_valid_o   = out_start_v_q;
  assign start_id_o      = out_start_id_q;
  assign start_type_o    = out_start_type_q;
  assign dispatch_ok_o   = out_disp_ok_q;
  assign running_o       = out_running_q;
  assign waiting_count_o = out_wait_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_queue_needs_current: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> cur_valid_q)
    else $error("waiting tasks with no current task");

  a_full_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status == ST_FULL) |=> ($stable(count_q) && $stable(ctr_q)))
    else $error("rejected add changed state");

  a_start_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_start_v_q) |-> out_running_q)
    else $error("task started but not running");

  a_notfound_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status == ST_NOT_FOUND) |=> $stable(count_q) && $stable(cur_valid_q))
    else $error("missed id changed state");

endmodule

/* sim/preemptive_task_queue_core_tb.sv */
// self-checking testbench of the preemptive task queue core with a scoreboard class
`timescale 1ns / 1ps

import ptq_pkg::*;

localparam logic [1:0] KIND_NONE = 2'd3;
localparam logic [1:0] MODE_ALT  = 2'd3;

typedef struct packed {
  logic [TGT_W-1:0]  id;
  logic [TYPE_W-1:0] ttype;
  logic              pre;
} job_t;

typedef struct packed {
  logic [TGT_W-1:0]  assigned_id;
  logic [1:0]        status;
  logic              stop_valid;
  logic [TGT_W-1:0]  stop_id;
  logic [TYPE_W-1:0] stop_type;
  logic              start_valid;
  logic [TGT_W-1:0]  start_id;
  logic [TYPE_W-1:0] start_type;
  logic              dispatch_ok;
  logic              running;
  logic [WAIT_W-1:0] waiting_count;
} outcome_t;

class task_queue_scoreboard;
  logic [MASK_W-1:0] type_mask = MASK_RESET;
  logic [TGT_W-1:0]  last_id = '0;
  logic              cur_valid = 1'b0;
  logic [TGT_W-1:0]  cur_id = '0;
  logic [TYPE_W-1:0] cur_type = '0;
  logic              cur_pre = 1'b0;
  job_t              waiting[$];
  outcome_t          expected_outcomes[$];
  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_full = 0;
  int n_miss = 0;
  int n_stops = 0;
  int n_starts = 0;

  function void halt_current(inout outcome_t r);
    r.stop_valid = 1'b1;
    r.stop_id    = cur_id;
    r.stop_type  = cur_type;
  endfunction

  function void launch(job_t j, inout outcome_t r);
    cur_valid     = 1'b1;
    cur_id        = j.id;
    cur_type      = j.ttype;
    cur_pre       = j.pre;
    r.start_valid = 1'b1;
    r.start_id    = j.id;
    r.start_type  = j.ttype;
    r.dispatch_ok = type_mask[j.ttype];
  endfunction

  function void note_item(logic [1:0] kind, logic [1:0] mode_in, logic pre,
                          logic [TYPE_W-1:0] ttype, logic [TGT_W-1:0] tgt);
    outcome_t   r;
    job_t       j;
    job_t       prev;
    logic [1:0] mode;
    int         hit;
    r = '0;
    hit = -1;
    mode = (mode_in == MODE_ALT) ? MODE_TAIL : mode_in;
    n_items++;
    if (kind == KIND_ADD) begin
      if (cur_valid && mode != MODE_CLEAR && waiting.size() >= QUEUE_DEPTH_DEF) begin
        r.status = ST_FULL;
      end else begin
        last_id = last_id + 1'b1;
        j = '{id: last_id, ttype: ttype, pre: pre};
        r.assigned_id = last_id;
        if (!cur_valid) begin
          launch(j, r);
        end else if (mode == MODE_TAIL) begin
          waiting.insert(waiting.size(), j);
        end else begin
          if (mode == MODE_CLEAR) waiting.delete();
          if (cur_pre) begin
            prev = '{id: cur_id, ttype: cur_type, pre: cur_pre};
            halt_current(r);
            if (mode == MODE_PREEMPT) waiting.insert(0, prev);
            launch(j, r);
          end else begin
            waiting.insert(0, j);
          end
        end
      end
    end else if (kind == KIND_DELETE || kind == KIND_FINISH) begin
      if (cur_valid && cur_id == tgt) begin
        if (kind == KIND_DELETE) halt_current(r);
        if (waiting.size() == 0) begin
          cur_valid = 1'b0;
        end else begin
          j = waiting[0];
          waiting.delete(0);
          launch(j, r);
        end
      end else begin
        foreach (waiting[i]) begin
          if (hit < 0 && waiting[i].id == tgt) hit = i;
        end
        if (hit >= 0) waiting.delete(hit);
        else r.status = ST_NOT_FOUND;
      end
    end
    r.running = cur_valid;
    r.waiting_count = WAIT_W'(waiting.size());
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_NOT_FOUND) n_miss++;
    if (r.stop_valid) n_stops++;
    if (r.start_valid) n_starts++;
    expected_outcomes.insert(expected_outcomes.size(), r);
  endfunction

  function void cmp(string fname, logic [TGT_W-1:0] exp_v, logic [TGT_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
    end
  endfunction

  function void check_result(outcome_t act);
    outcome_t e;
    if (expected_outcomes.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: result beat with nothing expected, expected none, actual id %0h",
                 $time, act.assigned_id);
      return;
    end
    e = expected_outcomes[0];
    expected_outcomes.delete(0);
    n_checked++;
    cmp("assigned_id", e.assigned_id, act.assigned_id);
    cmp("status", e.status, act.status);
    cmp("stop_valid", e.stop_valid, act.stop_valid);
    cmp("stop_id", e.stop_id, act.stop_id);
    cmp("stop_type", e.stop_type, act.stop_type);
    cmp("start_valid", e.start_valid, act.start_valid);
    cmp("start_id", e.start_id, act.start_id);
    cmp("start_type", e.start_type, act.start_type);
    cmp("dispatch_ok", e.dispatch_ok, act.dispatch_ok);
    cmp("running", e.running, act.running);
    cmp("waiting_count", e.waiting_count, act.waiting_count);
  endfunction

  function int pending();
    return expected_outcomes.size();
  endfunction
endclass

module preemptive_task_queue_core_tb;

  localparam int WATCHDOG_LIMIT = 5000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        kind_i = '0;
  logic [1:0]        preempt_mode_i = '0;
  logic              can_be_preempted_i = 1'b0;
  logic [TYPE_W-1:0] task_type_i = '0;
  logic [TGT_W-1:0]  target_id_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [TGT_W-1:0]  assigned_id_o;
  logic [1:0]        status_o;
  logic              stop_valid_o;
  logic [TGT_W-1:0]  stop_id_o;
  logic [TYPE_W-1:0] stop_type_o;
  logic              start_valid_o;
  logic [TGT_W-1:0]  start_id_o;
  logic [TYPE_W-1:0] start_type_o;
  logic              dispatch_ok_o;
  logic              running_o;
  logic [WAIT_W-1:0] waiting_count_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [MASK_W-1:0] cfg_data_i = '0;

  task_queue_scoreboard sb = new();

  int       tx_idle_pct = 0;
  int       rx_idle_pct = 0;
  logic     hold_rx = 1'b0;
  int       item_count = 0;
  int       add_bias = 50;
  int       idle_cycles = 0;
  outcome_t rx_beat;

  preemptive_task_queue_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .kind_i             (kind_i),
    .preempt_mode_i     (preempt_mode_i),
    .can_be_preempted_i (can_be_preempted_i),
    .task_type_i        (task_type_i),
    .target_id_i        (target_id_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .assigned_id_o      (assigned_id_o),
    .status_o           (status_o),
    .stop_valid_o       (stop_valid_o),
    .stop_id_o          (stop_id_o),
    .stop_type_o        (stop_type_o),
    .start_valid_o      (start_valid_o),
    .start_id_o         (start_id_o),
    .start_type_o       (start_type_o),
    .dispatch_ok_o      (dispatch_ok_o),
    .running_o          (running_o),
    .waiting_count_o    (waiting_count_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        rx_beat = '{assigned_id: assigned_id_o, status: status_o, stop_valid: stop_valid_o,
                    stop_id: stop_id_o, stop_type: stop_type_o, start_valid: start_valid_o,
                    start_id: start_id_o, start_type: start_type_o,
                    dispatch_ok: dispatch_ok_o, running: running_o,
                    waiting_count: waiting_count_o};
        sb.check_result(rx_beat);
      end
      out_stall_i <= hold_rx || ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("preemptive_task_queue_core_tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [1:0] mode, logic pre,
                           logic [TYPE_W-1:0] ttype, logic [TGT_W-1:0] tgt);
    in_valid_i         <= 1'b1;
    kind_i             <= kind;
    preempt_mode_i     <= mode;
    can_be_preempted_i <= pre;
    task_type_i        <= ttype;
    target_id_i        <= tgt;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(kind, mode, pre, ttype, tgt);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_random_item();
    logic [1:0]        kind;
    logic [1:0]        mode;
    logic              pre;
    logic [TYPE_W-1:0] ttype;
    logic [TGT_W-1:0]  tgt;
    int                pick;
    kind  = 2'($urandom);
    mode  = 2'($urandom);
    pre   = 1'($urandom);
    ttype = TYPE_W'($urandom);
    tgt   = $urandom;
    if ($urandom_range(99) >= 5) begin
      if (item_count % 100 == 0) add_bias = $urandom_range(30, 75);
      pick = $urandom_range(99);
      if (pick < add_bias) begin
        kind = KIND_ADD;
        pick = $urandom_range(99);
        mode = (pick < 45) ? MODE_TAIL : (pick < 80) ? MODE_PREEMPT :
               (pick < 86) ? MODE_CLEAR : MODE_ALT;
      end else begin
        kind = $urandom_range(1) ? KIND_FINISH : KIND_DELETE;
        pick = $urandom_range(99);
        if (pick < 55 && sb.cur_valid) tgt = sb.cur_id;
        else if (pick < 92 && sb.waiting.size() > 0)
          tgt = sb.waiting[$urandom_range(sb.waiting.size() - 1)].id;
      end
    end
    item_count++;
    send_item(kind, mode, pre, ttype, tgt);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_mask(logic [MASK_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.type_mask = value;
  endtask

  task automatic run_phase(int n, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    repeat (n) send_random_item();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle misses, fill to full, reject, preempt, clear, finish and delete of current
    rx_idle_pct <= 30;
    send_item(KIND_FINISH, MODE_TAIL, 1'b0, '0, '0);
    send_item(KIND_DELETE, MODE_TAIL, 1'b0, '0, '1);
    send_item(KIND_ADD, MODE_TAIL, 1'b1, 4'hF, '0);
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++) begin
      send_item(KIND_ADD, i[0] ? MODE_ALT : MODE_TAIL, i[0], i[TYPE_W-1:0], '0);
    end
    send_item(KIND_ADD, MODE_PREEMPT, 1'b1, 4'h1, '0);
    send_item(KIND_DELETE, MODE_TAIL, 1'b0, '0, 32'd9);
    send_item(KIND_ADD, MODE_PREEMPT, 1'b0, 4'h3, '0);
    send_item(KIND_ADD, MODE_CLEAR, 1'b1, 4'h0, '0);
    send_item(KIND_FINISH, MODE_TAIL, 1'b0, '0, 32'd18);
    send_item(KIND_ADD, MODE_CLEAR, 1'b0, 4'h2, '0);
    send_item(KIND_NONE, MODE_ALT, 1'b1, 4'hF, '1);
    send_item(KIND_DELETE, MODE_TAIL, 1'b0, '0, 32'd20);
    drain();

    write_mask('0);
    run_phase(700, 7, 68);
    drain();

    write_mask(MASK_W'($urandom));
    run_phase(700, 68, 7);
    drain();

    write_mask('1);
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (80) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
      repeat (100) send_random_item();
    join
    run_phase(500, 0, 0);
    drain();
    repeat (10) @(posedge clk_i);

    $display("run covered %0d items and %0d checked results over four type masks",
             sb.n_items, sb.n_checked);
    $display("  %0d full rejects, %0d misses, %0d stops, %0d dispatches",
             sb.n_full, sb.n_miss, sb.n_stops, sb.n_starts);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("preemptive_task_queue_core_tb: PASS");
    end else begin
      $display("preemptive_task_queue_core_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ptq_pkg.sv
hdl/ptq_cell.sv
hdl/preemptive_task_queue_core.sv
sim/preemptive_task_queue_core_tb.sv
